/* sv/bds_pkg.sv */
// package for the baud divisor search block
// types, constants and helpers shared by all modules; no dependencies
`timescale 1ns / 1ps
package bds_pkg;

  localparam int SBR_WIDTH   = 13;
  localparam int MAX_RATIO   = 32;
  localparam int FIRST_RATIO = 4;
  localparam int CLK_W       = 28;
  localparam int BAUD_W      = 23;
  localparam int OSR_W       = 5;
  localparam int RATIO_W     = 6;
  localparam int DIV_W       = 16;
  localparam int QUO_W       = 28;
  localparam int CNT_W       = 5;

  localparam logic [DIV_W-1:0] DIV_SAT = {DIV_W{1'b1}};
  localparam logic [OSR_W-1:0] EDGE_LOW  = OSR_W'(3);
  localparam logic [OSR_W-1:0] EDGE_HIGH = OSR_W'(6);

  typedef struct packed {
    logic [CLK_W-1:0]  clock_hz;
    logic [BAUD_W-1:0] baud_wanted;
  } query_t;

  typedef struct packed {
    logic [OSR_W-1:0]     osr_field;
    logic [SBR_WIDTH-1:0] sbr_divisor;
    logic                 both_edge;
    logic [CLK_W-1:0]     rate_error;
    logic                 divisor_overflow;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [QUO_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/bds_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on bds_pkg; a zero divisor yields an all-ones quotient
`timescale 1ns / 1ps
module bds_divider
  import bds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [QUO_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [QUO_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= QUO_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[QUO_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* sv/baud_divisor_search.sv */
// top level of the baud divisor search block
// depends on bds_pkg and bds_divider
//
// usage: a query transaction carries clock_hz and baud_wanted; one result
// transaction comes back with the chosen oversampling field, the divisor,
// the both-edge flag, the rate error and the divisor overflow flag.
// ratios 4 to 32 are tried in order; each trial needs two serial divisions
// (clock over baud times ratio, then clock over divisor times ratio) and a
// winning trial may add a third for divisor plus one.
// each division runs on the one shared bit-serial divider. a full search
// ends after ratio 32, or earlier on an exact match.
// query_stall stays high from the accepted query until its result is
// loaded into the output register; the next query is then taken at once
// even while that result still waits on result_stall.
// if the result is still stalled when a new search ends, the block holds
// the finished answer until the output register frees up.
// rst is synchronous and returns the block to idle with no result pending.
`timescale 1ns / 1ps
module baud_divisor_search
  import bds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_stall,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START1 = 4'd1;
  localparam logic [3:0] S_WAIT1  = 4'd2;
  localparam logic [3:0] S_START2 = 4'd3;
  localparam logic [3:0] S_WAIT2  = 4'd4;
  localparam logic [3:0] S_NEXT   = 4'd5;
  localparam logic [3:0] S_FINISH = 4'd6;

  logic [3:0]         state;
  logic [CLK_W-1:0]   clk_hz;
  logic [BAUD_W-1:0]  baud;
  logic [RATIO_W-1:0] ratio;
  logic               may_bump;
  logic               is_bump;
  logic               have_best;
  logic [OSR_W-1:0]   best_osr;
  logic [DIV_W-1:0]   best_div;
  logic [CLK_W-1:0]   best_err;
  logic [DIV_W-1:0]   trial_d;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [CLK_W-1:0]   err;
  logic [DIV_W-1:0]   q_sat;
  logic [DIV_W-1:0]   bump_d;
  logic               accept;
  logic               out_free;

  bds_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign accept   = query_valid && !query_stall;
  assign out_free = !result_valid || !result_stall;
  assign query_stall = (state != S_IDLE);

  // achieved rate against the wanted one
  always_comb begin
    if (drsp.quotient >= CLK_W'(baud)) begin
      err = drsp.quotient - CLK_W'(baud);
    end else begin
      err = CLK_W'(baud) - drsp.quotient;
    end
    // trial divisor saturates instead of wrapping
    if (|drsp.quotient[QUO_W-1:DIV_W]) begin
      q_sat = DIV_SAT;
    end else begin
      q_sat = drsp.quotient[DIV_W-1:0];
    end
    bump_d = (trial_d == DIV_SAT) ? DIV_SAT : trial_d + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dreq.start   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // divider start pulses in the cycle after a start state
      dreq.start <= (state == S_START1) || (state == S_START2);
      if (state == S_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_START1;
          end
        end
        S_START1: begin
          // first division: clock over baud times ratio
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (drsp.done) begin
            state <= S_START2;
          end
        end
        S_START2: begin
          // second division: clock over divisor times ratio
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (drsp.done) begin
            if (!is_bump && err == '0) begin
              state <= S_FINISH;
            end else if (!is_bump && (!have_best || err < best_err) && may_bump) begin
              state <= S_START2;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          state <= (ratio == RATIO_W'(MAX_RATIO)) ? S_FINISH : S_START1;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          clk_hz    <= query.clock_hz;
          baud      <= query.baud_wanted;
          ratio     <= RATIO_W'(FIRST_RATIO);
          may_bump  <= 1'b0;
          is_bump   <= 1'b0;
          have_best <= 1'b0;
        end
      end
      S_START1: begin
        dreq.dividend <= clk_hz;
        dreq.divisor  <= QUO_W'(baud) * QUO_W'(ratio);
      end
      S_WAIT1: begin
        if (drsp.done) begin
          if (drsp.quotient == '0) begin
            trial_d  <= DIV_W'(1);
            may_bump <= 1'b0;
          end else begin
            trial_d <= q_sat;
          end
        end
      end
      S_START2: begin
        dreq.dividend <= clk_hz;
        dreq.divisor  <= QUO_W'(trial_d) * QUO_W'(ratio);
      end
      S_WAIT2: begin
        if (drsp.done) begin
          if (is_bump) begin
            if (err < best_err) begin
              best_div <= trial_d;
              best_err <= err;
            end
          end else if (err == '0 || !have_best || err < best_err) begin
            best_osr  <= OSR_W'(ratio - 1'b1);
            best_div  <= trial_d;
            best_err  <= err;
            have_best <= 1'b1;
            if (err != '0 && may_bump) begin
              trial_d <= bump_d;
              is_bump <= 1'b1;
            end
          end
        end
      end
      S_NEXT: begin
        may_bump <= 1'b1;
        is_bump  <= 1'b0;
        ratio    <= ratio + 1'b1;
      end
      S_FINISH: begin
        if (out_free) begin
          result.osr_field        <= best_osr;
          result.sbr_divisor      <= best_div[SBR_WIDTH-1:0];
          result.both_edge        <= best_osr inside {[EDGE_LOW:EDGE_HIGH]};
          result.rate_error       <= best_err;
          result.divisor_overflow <= |best_div[DIV_W-1:SBR_WIDTH];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/bds_checker.sv */
// port-level checker for the baud divisor search block
// depends on bds_pkg; bound to baud_divisor_search below
`timescale 1ns / 1ps
module bds_checker
  import bds_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    query_valid,
  input logic    query_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    query_valid && !query_stall |=> query_stall)
    else $error("block took a second query while searching");

  a_edge_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.both_edge == (result.osr_field == 5'd3 ||
      result.osr_field == 5'd4 || result.osr_field == 5'd5 || result.osr_field == 5'd6))
    else $error("both_edge does not match osr_field");

  a_osr_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.osr_field >= 5'd3)
    else $error("osr_field below the first ratio");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result changed");

endmodule

bind baud_divisor_search bds_checker u_bds_checker (
  .clk          (clk),
  .rst          (rst),
  .query_valid  (query_valid),
  .query_stall  (query_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* dv/baud_divisor_search_test.sv */
// testbench for the baud divisor search block: directed and random queries,
// results checked against a behavioral divisor search in a scoreboard class
// depends on bds_pkg and the baud_divisor_search rtl
`timescale 1ns / 1ps
module baud_divisor_search_test;
  import bds_pkg::*;

  // behavioral search and queue of expected answers
  class divisor_scoreboard;
    result_t answers_due[$];

    // divider returns all ones for a zero divisor
    static function logic [31:0] quot(logic [31:0] a, logic [31:0] b);
      if (b == 0) return 32'hFFFF_FFFF;
      return a / b;
    endfunction

    static function logic [31:0] gap(logic [31:0] a, logic [31:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    static function result_t search(query_t q);
      logic [31:0] clk_hz, baud, lead_osr, lead_div, lead_err, d, d1, err, err1;
      logic        may_bump;
      result_t     res;
      clk_hz   = 32'(q.clock_hz);
      baud     = 32'(q.baud_wanted);
      lead_osr = 0;
      lead_div = 0;
      lead_err = 32'hFFFF_FFFF;
      may_bump = 1'b0;
      for (int r = FIRST_RATIO; r <= MAX_RATIO; r++) begin
        d = quot(clk_hz, baud * 32'(r));
        if (d == 0) begin
          d = 1;
          may_bump = 1'b0;
        end
        if (d > 32'(DIV_SAT)) d = 32'(DIV_SAT);
        err = gap(quot(clk_hz, d * 32'(r)), baud);
        if (err == 0) begin
          // exact match ends the search
          lead_osr = 32'(r - 1);
          lead_div = d;
          lead_err = 0;
          break;
        end
        if (err < lead_err) begin
          lead_osr = 32'(r - 1);
          lead_div = d;
          lead_err = err;
          if (may_bump) begin
            d1 = d + 1;
            if (d1 > 32'(DIV_SAT)) d1 = 32'(DIV_SAT);
            err1 = gap(quot(clk_hz, d1 * 32'(r)), baud);
            if (err1 < lead_err) begin
              lead_div = d1;
              lead_err = err1;
            end
          end
        end
        may_bump = 1'b1;
      end
      res.osr_field        = lead_osr[OSR_W-1:0];
      res.sbr_divisor      = lead_div[SBR_WIDTH-1:0];
      res.both_edge        = (lead_osr >= 32'(EDGE_LOW)) && (lead_osr <= 32'(EDGE_HIGH));
      res.rate_error       = lead_err[CLK_W-1:0];
      res.divisor_overflow = lead_div > ((32'd1 << SBR_WIDTH) - 1);
      return res;
    endfunction

    function void note_query(query_t q);
      answers_due.push_back(search(q));
    endfunction

    task check_result(result_t got);
      result_t want;
      if (answers_due.size() == 0) begin
        report_mismatch("result with no query outstanding", 0, 0);
        return;
      end
      want = answers_due.pop_front();
      if (got.osr_field != want.osr_field)
        report_mismatch("osr_field", got.osr_field, want.osr_field);
      if (got.sbr_divisor != want.sbr_divisor)
        report_mismatch("sbr_divisor", got.sbr_divisor, want.sbr_divisor);
      if (got.both_edge != want.both_edge)
        report_mismatch("both_edge", got.both_edge, want.both_edge);
      if (got.rate_error != want.rate_error)
        report_mismatch("rate_error", got.rate_error, want.rate_error);
      if (got.divisor_overflow != want.divisor_overflow)
        report_mismatch("divisor_overflow", got.divisor_overflow, want.divisor_overflow);
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_QUERIES = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    query_valid = 1'b0;
  logic    query_stall;
  query_t  query = '0;
  logic    result_valid;
  logic    result_stall = 1'b1;
  result_t result;

  divisor_scoreboard board = new();
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  stimulus_done = 1'b0;
  bit  hold_results = 1'b0;

  always #5 clk = ~clk;

  baud_divisor_search i_dut (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .query       (query),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // gap length: mostly short, sometimes long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // offer one query transaction and wait for its acceptance
  // valid drops only when a gap follows, so back to back offers keep it high
  task automatic send_query(logic [CLK_W-1:0] hz, logic [BAUD_W-1:0] baud);
    int gap_len;
    gap_len = idle_len();
    if (gap_len != 0) begin
      query_valid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    query.clock_hz    <= hz;
    query.baud_wanted <= baud;
    query_valid       <= 1'b1;
    @(posedge clk);
    while (query_stall) @(posedge clk);
    board.note_query(query);
    @(negedge clk);
  endtask

  // baud values near common rates, with the odd random one
  function automatic logic [BAUD_W-1:0] pick_baud();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return BAUD_W'($urandom_range(1, 300));
      1: return BAUD_W'($urandom_range(1, 8000000));
      2: return BAUD_W'($urandom);
      default: return BAUD_W'($urandom_range(9600, 921600));
    endcase
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return CLK_W'($urandom_range(0, 1000));
      1: return CLK_W'($urandom);
      default: return CLK_W'($urandom_range(1000000, 200000000));
    endcase
  endfunction

  // receiver side: random stalls, plus one long hold-off while the sender keeps offering
  initial begin
    int stretch;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        result_stall <= 1'b1;
        repeat (8000) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        stretch = idle_len();
        result_stall <= (stretch != 0);
        repeat (stretch == 0 ? $urandom_range(1, 30) : stretch) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (query_valid && !query_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, zero baud, zero clock, saturation, exact match
    send_query('0, '0);
    send_query('0, 1);
    send_query('1, 0);
    send_query('1, 1);
    send_query('1, '1);
    send_query(1, '1);
    send_query(1, 1);
    send_query(28'd48000000, 23'd115200);
    send_query(28'd48000000, 23'd9600);
    send_query(28'd16000000, 23'd500000);
    send_query(28'd4000000, 23'd1000000);
    send_query(28'd32000000, 23'd1000000);
    send_query(28'd12000000, 23'd300);
    send_query(28'd100, 23'd3);
    send_query(28'h5555555, 23'h2AAAAA);
    send_query(28'hAAAAAAA, 23'h555555);

    // receiver holds off while the sender keeps offering
    hold_results = 1'b1;
    for (int i = 0; i < 4; i++) send_query(pick_clock(), pick_baud());

    for (int i = 0; i < RANDOM_QUERIES; i++) send_query(pick_clock(), pick_baud());
    query_valid <= 1'b0;

    waited = 0;
    while (board.answers_due.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (100) @(negedge clk);
    if (mismatches == 0 && board.answers_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
